/* design/ple_pkg.sv */
// Shared types and constants for the positional list engine.
// Depends on nothing; ple_ctrl and the engine top import it.
`default_nettype none

package ple_pkg;

    // Default geometry of the element store.
    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_ELEM_BITS = 32;

    // Fixed widths of the beat fields.
    localparam int TYPE_BITS   = 3;
    localparam int POS_BITS    = 5;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 5;
    localparam int STATUS_BITS = 2;

    typedef enum logic [TYPE_BITS-1:0] {
        REQ_GET       = 3'd0,
        REQ_SET       = 3'd1,
        REQ_INSERT    = 3'd2,
        REQ_APPEND    = 3'd3,
        REQ_PREPEND   = 3'd4,
        REQ_REMOVE_AT = 3'd5,
        REQ_REMOVE_EQ = 3'd6,
        REQ_CLEAR     = 3'd7
    } req_kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_POS = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_DECODE  = 6'b000010,
        ST_GET     = 6'b000100,
        ST_SHIFT   = 6'b001000,
        ST_COMPACT = 6'b010000,
        ST_RESPOND = 6'b100000
    } state_t;

    // Finished result handed from the sequencer to the output register.
    typedef struct packed {
        logic [VALUE_BITS-1:0] read_value;
        logic [COUNT_BITS-1:0] element_count;
        logic                  list_empty;
        logic [COUNT_BITS-1:0] removed_count;
        status_t               status;
    } ple_result_t;

endpackage

`default_nettype wire

/* design/positional_list_engine.sv */
// Positional list engine: an ordered, bounded list of signed elements kept in
// a single-port-write, single-port-read memory. A request beat is taken only
// while the block is idle. Set, clear and every rejected request answer
// straight from decode, and get answers after one read of the store. Insert,
// append and prepend first move every entry from the target on one place
// toward the rear; remove at walks the entries from the position on, and
// remove equal walks the whole list. Each entry that moves passes once
// through the store's one read port and one write port. The sequencer
// returns to idle at the edge that loads the result, so a new request can be
// taken once the result is loaded. A result beat is held in an output
// register, so a new request can be accepted while the previous result
// still waits on out_stall. The store has no reset; only entries below the
// element count are ever used.
// Depends on ple_pkg, ple_mem and ple_ctrl.
`default_nettype none

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int ELEM_BITS = DEF_ELEM_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic [TYPE_BITS-1:0]          req_type,
    input  wire logic [POS_BITS-1:0]           position,
    input  wire logic signed [VALUE_BITS-1:0]  value,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic signed [VALUE_BITS-1:0]  read_value,
    output      logic [COUNT_BITS-1:0]         element_count,
    output      logic                          list_empty,
    output      logic [COUNT_BITS-1:0]         removed_count,
    output      logic [STATUS_BITS-1:0]        status
);

    localparam int AW = $clog2(CAPACITY);

    logic                   start;
    logic                   busy;
    logic                   res_valid;
    logic                   res_take;
    ple_result_t            res;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [ELEM_BITS-1:0]   wr_data;
    logic [AW-1:0]          rd_addr;
    logic signed [ELEM_BITS-1:0] rd_data;
    logic [ELEM_BITS-1:0]   req_value;

    logic        out_valid_reg;
    ple_result_t out_res_reg;

    // The request is accepted only while the sequencer is idle.
    assign in_stall = busy;
    assign start    = in_valid && !busy;

    // The incoming value is sign-extended or truncated to the element width.
    assign req_value = ELEM_BITS'(value);

    // The output register takes a result when it is empty or being drained.
    assign res_take = !out_valid_reg || !out_stall;

    ple_ctrl #(
        .CAPACITY  (CAPACITY),
        .ELEM_BITS (ELEM_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .req_pos   (position),
        .req_value (req_value),
        .busy      (busy),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    ple_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ELEM_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_value    = out_res_reg.read_value;
    assign element_count = out_res_reg.element_count;
    assign list_empty    = out_res_reg.list_empty;
    assign removed_count = out_res_reg.removed_count;
    assign status        = out_res_reg.status;

    // An accepted request keeps the block busy on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("request accepted without the sequencer going busy");

    // A result handed to the output register shows up as a valid beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_take |=> out_valid)
    else $error("finished result was lost before the output register");

    // A rejected request never removes anything.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> removed_count == '0)
    else $error("rejected request reports removed elements");

    // The shift and compaction walks never write while idle or responding.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy || res_valid |-> !wr_en)
    else $error("store written outside of a request");

endmodule

`default_nettype wire

/* design/ple_mem.sv */
// Element store: one write port and one read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module ple_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output      logic signed [WIDTH-1:0]    rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* design/ple_ctrl.sv */
// Sequencer of the positional list engine: decodes a request and walks the
// store one entry per cycle for shifts and compaction. Uses ple_pkg.
`default_nettype none

module ple_ctrl
    import ple_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int ELEM_BITS = DEF_ELEM_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [TYPE_BITS-1:0]         req_type,
    input  wire logic [POS_BITS-1:0]          req_pos,
    input  wire logic [ELEM_BITS-1:0]         req_value,
    output      logic                         busy,
    output      logic                         res_valid,
    input  wire logic                         res_take,
    output      ple_result_t                  res,
    output      logic                         wr_en,
    output      logic [$clog2(CAPACITY)-1:0]  wr_addr,
    output      logic [ELEM_BITS-1:0]         wr_data,
    output      logic [$clog2(CAPACITY)-1:0]  rd_addr,
    input  wire logic signed [ELEM_BITS-1:0]  rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_BITS) ? CW : POS_BITS;
    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] FULL = CW'(CAPACITY);

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  pend_reg, pend_next;
    req_kind_t             kind_reg, kind_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [ELEM_BITS-1:0]  val_reg, val_next;
    logic [CW-1:0]         cur_reg, cur_next;
    logic [CW-1:0]         dst_reg, dst_next;
    logic [CW-1:0]         tgt_reg, tgt_next;
    logic [CW-1:0]         pend_idx_reg, pend_idx_next;
    logic [VALUE_BITS-1:0] read_reg, read_next;
    status_t               status_reg, status_next;
    logic [CW-1:0]         removed_reg, removed_next;

    logic pos_lt;
    logic pos_le;
    logic drop;

    assign pos_lt = XW'(pos_reg) <  XW'(count_reg);
    assign pos_le = XW'(pos_reg) <= XW'(count_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        pend_next     = pend_reg;
        kind_next     = kind_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        cur_next      = cur_reg;
        dst_next      = dst_reg;
        tgt_next      = tgt_reg;
        pend_idx_next = pend_idx_reg;
        read_next     = read_reg;
        status_next   = status_reg;
        removed_next  = removed_reg;
        wr_en         = 1'b0;
        wr_addr       = pend_idx_reg[AW-1:0];
        wr_data       = rd_data;
        rd_addr       = cur_reg[AW-1:0];
        drop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next  = req_kind_t'(req_type);
                    pos_next   = req_pos;
                    val_next   = req_value;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                read_next    = '0;
                status_next  = STAT_OK;
                removed_next = '0;
                rd_addr      = AW'(pos_reg);
                state_next   = ST_RESPOND;
                case (kind_reg)
                    REQ_GET:
                    begin
                        if (!pos_lt)
                        begin
                            status_next = STAT_BAD_POS;
                        end
                        else
                        begin
                            state_next = ST_GET;
                        end
                    end
                    REQ_SET:
                    begin
                        if (!pos_lt)
                        begin
                            status_next = STAT_BAD_POS;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(pos_reg);
                            wr_data = val_reg;
                        end
                    end
                    REQ_INSERT, REQ_APPEND, REQ_PREPEND:
                    begin
                        if (kind_reg == REQ_INSERT && !pos_le)
                        begin
                            status_next = STAT_BAD_POS;
                        end
                        else if (count_reg == FULL)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            cur_next  = count_reg;
                            pend_next = 1'b0;
                            if (kind_reg == REQ_INSERT)
                            begin
                                tgt_next = CW'(pos_reg);
                            end
                            else if (kind_reg == REQ_APPEND)
                            begin
                                tgt_next = count_reg;
                            end
                            else
                            begin
                                tgt_next = '0;
                            end
                            state_next = ST_SHIFT;
                        end
                    end
                    REQ_REMOVE_AT:
                    begin
                        if (!pos_lt)
                        begin
                            status_next = STAT_BAD_POS;
                        end
                        else
                        begin
                            cur_next   = CW'(pos_reg);
                            dst_next   = CW'(pos_reg);
                            pend_next  = 1'b0;
                            state_next = ST_COMPACT;
                        end
                    end
                    REQ_REMOVE_EQ:
                    begin
                        cur_next   = '0;
                        dst_next   = '0;
                        pend_next  = 1'b0;
                        state_next = ST_COMPACT;
                    end
                    default:
                    begin
                        removed_next = count_reg;
                        count_next   = '0;
                    end
                endcase
            end

            ST_GET:
            begin
                read_next  = VALUE_BITS'(rd_data);
                state_next = ST_RESPOND;
            end

            ST_SHIFT:
            begin
                // The write port either lands the entry read last cycle one
                // place toward the rear, or finally drops the new element in.
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_idx_reg[AW-1:0];
                    wr_data = rd_data;
                end
                else if (cur_reg == tgt_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = tgt_reg[AW-1:0];
                    wr_data    = val_reg;
                    count_next = count_reg + ONE;
                    state_next = ST_RESPOND;
                end
                if (cur_reg > tgt_reg)
                begin
                    rd_addr       = AW'(cur_reg - ONE);
                    pend_next     = 1'b1;
                    pend_idx_next = cur_reg;
                    cur_next      = cur_reg - ONE;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            ST_COMPACT:
            begin
                // Read at the source cursor; in the cycle after, keep the entry by writing
                // it at the destination cursor, or drop it.
                if (pend_reg)
                begin
                    if (kind_reg == REQ_REMOVE_AT)
                    begin
                        drop = XW'(pend_idx_reg) == XW'(pos_reg);
                    end
                    else
                    begin
                        drop = rd_data == val_reg;
                    end
                    if (!drop)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = dst_reg[AW-1:0];
                        wr_data  = rd_data;
                        dst_next = dst_reg + ONE;
                    end
                end
                if (cur_reg < count_reg)
                begin
                    rd_addr       = cur_reg[AW-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = cur_reg;
                    cur_next      = cur_reg + ONE;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        removed_next = count_reg - dst_reg;
                        count_next   = dst_reg;
                        state_next   = ST_RESPOND;
                    end
                end
            end

            ST_RESPOND:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        cur_reg      <= cur_next;
        dst_reg      <= dst_next;
        tgt_reg      <= tgt_next;
        pend_idx_reg <= pend_idx_next;
        read_reg     <= read_next;
        status_reg   <= status_next;
        removed_reg  <= removed_next;
    end

    assign busy      = state_reg != ST_IDLE;
    assign res_valid = state_reg == ST_RESPOND;

    assign res.read_value    = read_reg;
    assign res.element_count = COUNT_BITS'(count_reg);
    assign res.list_empty    = count_reg == '0;
    assign res.removed_count = COUNT_BITS'(removed_reg);
    assign res.status        = status_reg;

endmodule

`default_nettype wire
